>>> rtl/core/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg: shared types and constants for the single-server queue tick block
// Holds the queue geometry, the stored entry layout, the controller states
// and the ring index helper.
// ----------------------------------------------------------------------------
package ssq_pkg;

    // Ring storage geometry: the ring holds QUEUE_DEPTH-1 requests
    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = (IDX_W > 7) ? IDX_W : 7;

    typedef logic [IDX_W-1:0] t_idx;

    // One queued request
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] arrived;
        logic [7:0]  len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_DONE
    } t_state;

    // Advance a ring index with wrap at the last slot
    function automatic t_idx ring_next(input t_idx i);
        return (i == t_idx'(QUEUE_DEPTH - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

endpackage

>>> rtl/core/ssq_ram.sv
// ----------------------------------------------------------------------------
// ssq_ram: generic single-write, single-read synchronous RAM
// Read data is registered and updates only when a read is enabled.
// ----------------------------------------------------------------------------
module ssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/single_server_queue_tick_top.sv
// ----------------------------------------------------------------------------
// single_server_queue_tick_top: one-server queue simulator, one tick per word
// Each input word is one tick carrying an optional arrival; each tick yields
// exactly one result word with counters and the request that began service.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_request_arrives and
//   i_service_ticks. A word is taken when valid is high and stall is low.
//   Output channel: o_out_valid / i_out_stall carry the tick result.
//   Every input word produces exactly one output word, in order.
//   The result is registered in the retire state, after the accept state.
//   A new word is not taken until the last one retires. The queue lives in
//   a RAM with a registered read, so the head entry is read in the accept
//   state (S_IDLE) and retired in S_DONE; o_in_stall is high in S_DONE.
//   An arrival pushed into the slot being read in the same tick is
//   forwarded around the RAM.
//   A finished result waits in the output register while the next word is
//   accepted; if that register is still held by i_out_stall, the block
//   holds the second word in its retire cycle until the result is taken.
//   Reset (synchronous, active low) clears all counters, the ring indices,
//   the server and the output valid. The RAM needs no clearing: only
//   entries already written are ever read.
// ----------------------------------------------------------------------------
module single_server_queue_tick_top
    import ssq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_request_arrives,
    input  logic [7:0]  i_service_ticks,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_current_tick,
    output logic        o_service_started,
    output logic [15:0] o_started_id,
    output logic [15:0] o_started_wait,
    output logic [15:0] o_served_count,
    output logic [31:0] o_total_wait,
    output logic [6:0]  o_waiting_count,
    output logic        o_arrival_dropped
);

    // Control state
    t_state      r_state, n_state;
    logic [15:0] r_tick, r_next_id, r_served;
    logic [31:0] r_wait_sum;
    logic [7:0]  r_busy;
    t_idx        r_head, r_tail;
    logic        r_pop, r_drop, r_fwd_hit;
    t_entry      r_fwd_data;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_tick, r_out_id, r_out_wait, r_out_served;
    logic [31:0] r_out_total;
    logic [6:0]  r_out_count;
    logic        r_out_started, r_out_drop;

    logic        in_fire, retire;

    // Accept-cycle signals
    logic [15:0] tick_inc;
    t_idx        tail_nxt, head_nxt, tail_upd;
    logic        push, pop;
    t_entry      wr_entry;

    // Retire-cycle signals
    t_entry      rd_entry, head_entry;
    logic [15:0] swait;
    logic [32:0] wait_acc;
    logic [IDX_W:0]   cnt_diff;
    logic [CNT_W-1:0] cnt_ext;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DONE;
            S_DONE: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        retire     = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_DONE: retire = !r_out_valid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign in_fire = i_in_valid && !o_in_stall;

    // Push decision and pop decision for this tick
    assign tick_inc = r_tick + 16'd1;
    assign tail_nxt = ring_next(r_tail);
    assign head_nxt = ring_next(r_head);
    assign push     = i_request_arrives && (tail_nxt != r_head);
    assign tail_upd = push ? tail_nxt : r_tail;
    assign pop      = (r_busy == 8'd0) && (r_head != tail_upd);

    assign wr_entry.id      = r_next_id;
    assign wr_entry.arrived = tick_inc;
    assign wr_entry.len     = i_service_ticks;

    // Queue storage: write the pushed entry, read the slot after head
    ssq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && push),
        .i_waddr (tail_nxt),
        .i_wdata (wr_entry),
        .i_re    (in_fire),
        .i_raddr (head_nxt),
        .o_rdata (rd_entry)
    );

    // Forward an entry written into the slot read in the same cycle
    assign head_entry = r_fwd_hit ? r_fwd_data : rd_entry;
    assign swait      = r_tick - head_entry.arrived;
    assign wait_acc   = {1'b0, r_wait_sum} + 33'(swait);

    // Queue occupancy, modulo depth, kept to its low 7 bits
    always_comb begin
        cnt_diff = {1'b0, r_tail} - {1'b0, r_head};
        if (r_tail < r_head) begin
            cnt_diff = cnt_diff + (IDX_W+1)'(QUEUE_DEPTH);
        end
        cnt_ext = CNT_W'(cnt_diff[IDX_W-1:0]);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_next_id   <= '0;
            r_served    <= '0;
            r_wait_sum  <= '0;
            r_busy      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_pop       <= 1'b0;
            r_drop      <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // advance the tick, push, and count down or claim the head
            if (in_fire) begin
                r_tick    <= tick_inc;
                r_tail    <= tail_upd;
                r_next_id <= push ? r_next_id + 16'd1 : r_next_id;
                r_drop    <= i_request_arrives && !push;
                r_pop     <= pop;
                r_fwd_hit <= push && (tail_nxt == head_nxt);
                if (pop) begin
                    r_head <= head_nxt;
                end
                if (r_busy != 8'd0) begin
                    r_busy <= r_busy - 8'd1;
                end
            end
            // start service of the claimed head
            if (retire && r_pop) begin
                r_served   <= r_served + 16'd1;
                r_wait_sum <= wait_acc[32] ? '1 : wait_acc[31:0];
                r_busy     <= (head_entry.len != 8'd0) ? head_entry.len - 8'd1 : 8'd0;
            end
            // hold the result until taken
            if (retire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Forwarded entry payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fwd_data <= wr_entry;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_out_tick    <= r_tick;
            r_out_started <= r_pop;
            r_out_id      <= r_pop ? head_entry.id : 16'd0;
            r_out_wait    <= r_pop ? swait : 16'd0;
            r_out_served  <= r_pop ? r_served + 16'd1 : r_served;
            r_out_total   <= r_pop ? (wait_acc[32] ? '1 : wait_acc[31:0]) : r_wait_sum;
            r_out_count   <= cnt_ext[6:0];
            r_out_drop    <= r_drop;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_current_tick    = r_out_tick;
    assign o_service_started = r_out_started;
    assign o_started_id      = r_out_id;
    assign o_started_wait    = r_out_wait;
    assign o_served_count    = r_out_served;
    assign o_total_wait      = r_out_total;
    assign o_waiting_count   = r_out_count;
    assign o_arrival_dropped = r_out_drop;

endmodule

>>> rtl/core/ssq_chk.sv
// ----------------------------------------------------------------------------
// ssq_chk: port-level checks for the single-server queue tick block
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module ssq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_current_tick,
    input logic        o_service_started,
    input logic [15:0] o_started_id,
    input logic [15:0] o_started_wait,
    input logic [31:0] o_total_wait
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_current_tick)
            && $stable(o_total_wait))
        else $error("stalled result word changed");

    // Only one tick in flight: an accepted word blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while a tick is in flight");

    // Started fields are zero when nothing started
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_service_started |->
            o_started_id == 16'd0 && o_started_wait == 16'd0)
        else $error("start fields set without a started request");

    // Total wait never decreases across consecutive result words
    a_wait_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid |->
            o_total_wait >= $past(o_total_wait))
        else $error("total wait decreased");

endmodule

bind single_server_queue_tick_top ssq_chk u_ssq_chk (.*);

>>> tb/single_server_queue_tick_tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for single_server_queue_tick_top
// Drives tick words with optional arrivals through the valid/stall input
// channel. A scoreboard keeps its own model of the queue, the server and the
// counters, and compares every result word field by field. The run covers
// light and heavy load, a full queue with dropped arrivals, full drains and a
// long output hold-off.
// ----------------------------------------------------------------------------
module tb
    import ssq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_PRINTS   = 50;

    // one result word
    typedef struct packed {
        logic [15:0] current_tick;
        logic        service_started;
        logic [15:0] started_id;
        logic [15:0] started_wait;
        logic [15:0] served_count;
        logic [31:0] total_wait;
        logic [6:0]  waiting_count;
        logic        arrival_dropped;
    } t_tick_result;

    // traffic shapes for the random part
    typedef enum int {
        LOAD_LIGHT,
        LOAD_BURST,
        LOAD_MIXED,
        LOAD_DRAIN
    } t_load_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: queue/server model plus the store of expected result words
    // ------------------------------------------------------------------------
    class tick_scoreboard;
        logic [15:0]  tick_now;
        logic [15:0]  id_next;
        logic [15:0]  served_n;
        logic [31:0]  wait_acc;
        logic [7:0]   busy_left;
        t_idx         head_q;
        t_idx         tail_q;
        t_entry       ring_mem [QUEUE_DEPTH];
        t_tick_result expected_ticks [$];
        int           mismatches;

        function new();
            tick_now   = '0;
            id_next    = '0;
            served_n   = '0;
            wait_acc   = '0;
            busy_left  = '0;
            head_q     = '0;
            tail_q     = '0;
            mismatches = 0;
        endfunction

        function t_idx next_slot(t_idx i);
            int n;
            n = int'(i) + 1;
            return t_idx'((n >= QUEUE_DEPTH) ? 0 : n);
        endfunction

        function int backlog();
            return (int'(tail_q) + QUEUE_DEPTH - int'(head_q)) % QUEUE_DEPTH;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        // Advance the model by one accepted tick word and queue its result
        function void note_tick(bit arrives, logic [7:0] len);
            t_tick_result r;
            t_idx         slot;
            t_entry       e;
            logic [32:0]  acc;
            r = '0;
            tick_now = tick_now + 16'd1;

            // push the arrival, or drop it when the ring is full
            if (arrives) begin
                slot = next_slot(tail_q);
                if (slot == head_q) begin
                    r.arrival_dropped = 1'b1;
                end else begin
                    tail_q    = slot;
                    e.id      = id_next;
                    e.arrived = tick_now;
                    e.len     = len;
                    ring_mem[slot] = e;
                    id_next   = id_next + 16'd1;
                end
            end

            // count down a busy server, else start the head request
            if (busy_left != 8'd0) begin
                busy_left = busy_left - 8'd1;
            end else if (head_q != tail_q) begin
                head_q            = next_slot(head_q);
                e                 = ring_mem[head_q];
                r.service_started = 1'b1;
                r.started_id      = e.id;
                r.started_wait    = tick_now - e.arrived;
                served_n          = served_n + 16'd1;
                acc               = {1'b0, wait_acc} + {17'd0, r.started_wait};
                wait_acc          = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
                busy_left         = (e.len != 8'd0) ? e.len - 8'd1 : 8'd0;
            end

            r.current_tick  = tick_now;
            r.served_count  = served_n;
            r.total_wait    = wait_acc;
            r.waiting_count = 7'(backlog());
            expected_ticks.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task compare_field(string name, logic [15:0] tick, logic [31:0] want,
                           logic [31:0] got);
            if (got !== want)
                report_mismatch($sformatf("tick %0d %s: got 0x%0h, want 0x%0h",
                                          tick, name, got, want));
        endtask

        // Check one accepted result word against the oldest expectation
        task check_result(t_tick_result got);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, tick %0d",
                                          got.current_tick));
            end else begin
                want = expected_ticks.pop_front();
                compare_field("current_tick", want.current_tick,
                              32'(want.current_tick), 32'(got.current_tick));
                compare_field("service_started", want.current_tick,
                              32'(want.service_started), 32'(got.service_started));
                compare_field("started_id", want.current_tick,
                              32'(want.started_id), 32'(got.started_id));
                compare_field("started_wait", want.current_tick,
                              32'(want.started_wait), 32'(got.started_wait));
                compare_field("served_count", want.current_tick,
                              32'(want.served_count), 32'(got.served_count));
                compare_field("total_wait", want.current_tick,
                              want.total_wait, got.total_wait);
                compare_field("waiting_count", want.current_tick,
                              32'(want.waiting_count), 32'(got.waiting_count));
                compare_field("arrival_dropped", want.current_tick,
                              32'(want.arrival_dropped), 32'(got.arrival_dropped));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_arrives = 1'b0;
    logic [7:0]  in_len    = 8'd0;
    logic        out_stall = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [15:0] out_current_tick;
    logic        out_service_started;
    logic [15:0] out_started_id;
    logic [15:0] out_started_wait;
    logic [15:0] out_served_count;
    logic [31:0] out_total_wait;
    logic [6:0]  out_waiting_count;
    logic        out_arrival_dropped;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int ticks_sent    = 0;

    tick_scoreboard sb = new();

    single_server_queue_tick_top uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_request_arrives (in_arrives),
        .i_service_ticks   (in_len),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_current_tick    (out_current_tick),
        .o_service_started (out_service_started),
        .o_started_id      (out_started_id),
        .o_started_wait    (out_started_wait),
        .o_served_count    (out_served_count),
        .o_total_wait      (out_total_wait),
        .o_waiting_count   (out_waiting_count),
        .o_arrival_dropped (out_arrival_dropped)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Output side: take result words, stall at random or on a hold-off request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        t_tick_result seen;
        int           hold_left;
        int           holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                seen.current_tick    = out_current_tick;
                seen.service_started = out_service_started;
                seen.started_id      = out_started_id;
                seen.started_wait    = out_started_wait;
                seen.served_count    = out_served_count;
                seen.total_wait      = out_total_wait;
                seen.waiting_count   = out_waiting_count;
                seen.arrival_dropped = out_arrival_dropped;
                sb.check_result(seen);
            end
            // start a long hold-off when one is requested
            if (hold_reqs != holds_seen) begin
                holds_seen++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long without any word moving
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side tasks
    // ------------------------------------------------------------------------

    // Offer one tick word after a random gap and hold it until accepted
    task automatic send_tick(input bit arrives, input logic [7:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_arrives <= arrives;
        in_len     <= len;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(arrives, len);
        ticks_sent++;
    endtask

    // Stop offering and wait until every expected word has come back
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Feed ticks without arrivals until the ring is empty and the server idle
    task automatic drain_queue();
        while (sb.backlog() != 0 || sb.busy_left != 8'd0)
            send_tick(1'b0, 8'($urandom_range(1, 255)));
    endtask

    // Edges of the fields, zero length, start on arrival, waits behind a server
    task automatic run_directed();
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'h01);
        send_tick(1'b1, 8'h00);
        send_tick(1'b1, 8'h00);
        send_tick(1'b0, 8'h00);
        send_tick(1'b1, 8'hFF);
        send_tick(1'b1, 8'h80);
        send_tick(1'b1, 8'h7F);
        send_tick(1'b1, 8'hAA);
        send_tick(1'b1, 8'h55);
        send_tick(1'b0, 8'h01);
        send_tick(1'b1, 8'h02);
        send_tick(1'b0, 8'hFE);
        send_tick(1'b1, 8'h01);
        send_tick(1'b0, 8'h00);
        drain_queue();
        send_tick(1'b0, 8'h10);
        send_tick(1'b1, 8'h03);
        send_tick(1'b1, 8'h01);
    endtask

    // Random segments of varying load until the tick budget is spent
    task automatic run_random(input int items);
        int         stop;
        int         n;
        t_load_mode mode;
        stop = ticks_sent + items;
        while (ticks_sent < stop) begin
            mode = t_load_mode'($urandom_range(0, 3));
            n    = $urandom_range(40, 180);
            // clamp the segment length to the remaining budget
            if (n > stop - ticks_sent)
                n = stop - ticks_sent;
            case (mode)
                LOAD_LIGHT: begin
                    repeat (n)
                        send_tick($urandom_range(0, 99) < 30, 8'($urandom_range(1, 4)));
                end
                // one long service, then arrivals every tick that can fill the ring
                LOAD_BURST: begin
                    send_tick(1'b1, 8'($urandom_range(200, 255)));
                    repeat (n)
                        send_tick(1'b1, 8'($urandom_range(1, 3)));
                end
                LOAD_MIXED: begin
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0)
                            send_tick(1'($urandom_range(0, 1)),
                                      8'($urandom_range(1, 255)));
                        else
                            send_tick(1'($urandom_range(0, 1)),
                                      8'($urandom_range(1, 6)));
                    end
                end
                default: begin
                    // drain without arrivals, bounded by the budget
                    while ((sb.backlog() != 0 || sb.busy_left != 8'd0) && ticks_sent < stop)
                        send_tick(1'b0, 8'($urandom_range(1, 255)));
                    repeat ($urandom_range(1, 5))
                        send_tick(1'b0, 8'($urandom_range(1, 255)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 28;
        recv_idle_pct = 83;
        run_directed();
        run_random(230);
        pause_until_drained();

        // sender idles heavily, receiver lightly
        send_idle_pct = 83;
        recv_idle_pct = 28;
        run_random(230);
        pause_until_drained();

        // full rate; hold the output long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs     = hold_reqs + 1;
        run_random(210);
        pause_until_drained();

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
